// ===== sv/seven_segment_number_display_core_macros.svh =====
// ----------------------------------------------------------------------------
// seven segment display core assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_DISPLAY_CORE_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_DISPLAY_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SSND_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSND_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ssnd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssnd_pkg
// types, constants and segment table of the seven segment display core
// ----------------------------------------------------------------------------
`default_nettype none

package ssnd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int SCAN_W      = $clog2(DIGIT_COUNT);
    localparam int VALUE_W     = 32;
    localparam int SEG_W       = 8;

    // magnitude of an in-range value fits 24 bits (at most 9999000)
    localparam int MAG_W       = 24;
    localparam int RECIP_W     = MAG_W + 1;
    localparam int PROD_W      = MAG_W + RECIP_W;

    // decimal places of the magnitude, thousandths up to thousands
    localparam int PLACE_COUNT = 7;
    localparam int UNITS_PLACE = 3;

    localparam logic signed [VALUE_W-1:0] SAT_HI_LIMIT = 32'sd9999000;
    localparam logic signed [VALUE_W-1:0] SAT_LO_LIMIT = -32'sd999000;

    localparam logic [SEG_W-1:0] PAT_POINT = 8'h80;
    localparam logic [SEG_W-1:0] PAT_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] PAT_BLANK = 8'h00;

    localparam logic [DIGIT_COUNT-1:0] SEL_NONE = '0;
    localparam logic [DIGIT_COUNT-1:0] SEL_LEFT = DIGIT_COUNT'(1) << (DIGIT_COUNT - 1);

    localparam logic FUNC_SCAN = 1'b1;

    typedef logic [3:0] bcd_t;

    localparam bcd_t MAX_DIGIT = 4'd9;

    // floor(n / 10^k) = (n * ceil(2^s / 10^k)) >> s for every n below 2^MAG_W,
    // with s = MAG_W + ceil(log2(10^k))
    localparam int DIV_SHIFT [1:PLACE_COUNT-1] = '{28, 31, 34, 38, 41, 44};

    localparam logic [RECIP_W-1:0] DIV_RECIP [1:PLACE_COUNT-1] = '{
        RECIP_W'(((64'd1 << 28) + 64'd9)      / 64'd10),
        RECIP_W'(((64'd1 << 31) + 64'd99)     / 64'd100),
        RECIP_W'(((64'd1 << 34) + 64'd999)    / 64'd1000),
        RECIP_W'(((64'd1 << 38) + 64'd9999)   / 64'd10000),
        RECIP_W'(((64'd1 << 41) + 64'd99999)  / 64'd100000),
        RECIP_W'(((64'd1 << 44) + 64'd999999) / 64'd1000000)
    };

    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
    };

    // position 0 is the leftmost digit
    typedef logic [DIGIT_COUNT-1:0][SEG_W-1:0] pattern_set_t;

    typedef struct packed {
        logic         scan;
        pattern_set_t patterns;
    } fmt_item_t;

    function automatic logic [SEG_W-1:0] seg_of_digit(input bcd_t d);
        logic [SEG_W-1:0] p;
        p = PAT_BLANK;
        if (d <= MAX_DIGIT)
        begin
            p = SEG_TABLE[d];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssnd_in_if.sv =====
// ----------------------------------------------------------------------------
// ssnd_in_if
// command channel: load a value or advance the scan
// ----------------------------------------------------------------------------
`default_nettype none

interface ssnd_in_if
    import ssnd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [VALUE_W-1:0] value_milli;

    modport source (output valid, output func, output value_milli, input ready);
    modport sink   (input valid, input func, input value_milli, output ready);
endinterface

`default_nettype wire

// ===== sv/ssnd_out_if.sv =====
// ----------------------------------------------------------------------------
// ssnd_out_if
// display channel: segment pattern and one-hot digit select
// ----------------------------------------------------------------------------
`default_nettype none

interface ssnd_out_if
    import ssnd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SEG_W-1:0]       segments;
    logic [DIGIT_COUNT-1:0] digit_select;

    modport source (output valid, output segments, output digit_select, input ready);
    modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

`default_nettype wire

// ===== sv/ssnd_convert.sv =====
// ----------------------------------------------------------------------------
// ssnd_convert
// three-stage pipeline turning a value in thousandths into digit patterns
// ----------------------------------------------------------------------------
`default_nettype none

module ssnd_convert
    import ssnd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssnd_in_if.sink    cmd,
    input  wire logic  take,
    output fmt_item_t  item,
    output logic       item_valid
);

    // stage 0: input register
    logic                      s0_valid_reg, s0_valid_next;
    logic                      s0_func_reg;
    logic signed [VALUE_W-1:0] s0_value_reg;

    // stage 1: range flags and magnitude
    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_func_reg, s1_hi_reg, s1_lo_reg, s1_neg_reg;
    logic                      s1_hi_next, s1_lo_next;
    logic [MAG_W-1:0]          s1_mag_reg, s1_mag_next;
    logic [VALUE_W-1:0]        mag_full;

    // stage 2: low nibble of each decimal quotient
    logic                      s2_valid_reg, s2_valid_next;
    logic                      s2_func_reg, s2_hi_reg, s2_lo_reg, s2_neg_reg;
    bcd_t                      s2_nib_reg  [PLACE_COUNT];
    bcd_t                      s2_nib_next [PLACE_COUNT];
    logic [PROD_W-1:0]         quot_prod   [1:PLACE_COUNT-1];

    logic                      ready0, ready1, ready2;
    bcd_t                      digit [PLACE_COUNT];
    logic [1:0]                lead;

    assign ready2    = !s2_valid_reg || take;
    assign ready1    = !s1_valid_reg || ready2;
    assign ready0    = !s0_valid_reg || ready1;
    assign cmd.ready = ready0;

    assign s0_valid_next = ready0 ? cmd.valid    : s0_valid_reg;
    assign s1_valid_next = ready1 ? s0_valid_reg : s1_valid_reg;
    assign s2_valid_next = ready2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // range check and absolute value
    assign s1_hi_next  = s0_value_reg > SAT_HI_LIMIT;
    assign s1_lo_next  = s0_value_reg < SAT_LO_LIMIT;
    assign mag_full    = s0_value_reg[VALUE_W-1] ? VALUE_W'(-s0_value_reg)
                                                 : VALUE_W'(s0_value_reg);
    assign s1_mag_next = mag_full[MAG_W-1:0];

    // reciprocal multiplications, one per decimal place above the thousandths, side by side
    assign s2_nib_next[0] = s1_mag_reg[3:0];

    for (genvar k = 1; k < PLACE_COUNT; k++)
    begin : g_quot
        assign quot_prod[k]   = PROD_W'(s1_mag_reg) * PROD_W'(DIV_RECIP[k]);
        assign s2_nib_next[k] = quot_prod[k][DIV_SHIFT[k] +: 4];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && ready0)
        begin
            s0_func_reg  <= cmd.func;
            s0_value_reg <= cmd.value_milli;
        end
        if (s0_valid_reg && ready1)
        begin
            s1_func_reg <= s0_func_reg;
            s1_hi_reg   <= s1_hi_next;
            s1_lo_reg   <= s1_lo_next;
            s1_neg_reg  <= s0_value_reg[VALUE_W-1];
            s1_mag_reg  <= s1_mag_next;
        end
        if (s1_valid_reg && ready2)
        begin
            s2_func_reg <= s1_func_reg;
            s2_hi_reg   <= s1_hi_reg;
            s2_lo_reg   <= s1_lo_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_nib_reg  <= s2_nib_next;
        end
    end

    // digit = quotient - 10 * next quotient, exact in four bits
    always_comb
    begin
        for (int k = 0; k < PLACE_COUNT - 1; k++)
        begin
            digit[k] = 4'(s2_nib_reg[k] - 4'((s2_nib_reg[k+1] << 3) + (s2_nib_reg[k+1] << 1)));
        end
        digit[PLACE_COUNT-1] = s2_nib_reg[PLACE_COUNT-1];
    end

    // suppressed leading zeros, stopping at the units place
    always_comb
    begin
        if (s2_neg_reg)
        begin
            if (digit[5] != '0)
                lead = 2'd0;
            else if (digit[4] != '0)
                lead = 2'd1;
            else
                lead = 2'd2;
        end
        else
        begin
            if (digit[6] != '0)
                lead = 2'd0;
            else if (digit[5] != '0)
                lead = 2'd1;
            else if (digit[4] != '0)
                lead = 2'd2;
            else
                lead = 2'd3;
        end
    end

    // same window for both signs: place = 6 - lead - position
    always_comb
    begin
        logic [2:0] idx;
        idx = '0;
        for (int j = 0; j < DIGIT_COUNT; j++)
        begin
            idx = 3'(PLACE_COUNT - 1 - int'(lead) - j);
            item.patterns[j] = seg_of_digit(digit[idx])
                             | ((idx == 3'(UNITS_PLACE)) ? PAT_POINT : PAT_BLANK);
        end
        if (s2_neg_reg)
        begin
            item.patterns[0] = PAT_MINUS;
        end
        if (s2_hi_reg || s2_lo_reg)
        begin
            for (int j = 0; j < DIGIT_COUNT; j++)
            begin
                item.patterns[j] = seg_of_digit(MAX_DIGIT);
            end
            item.patterns[DIGIT_COUNT-1] = seg_of_digit(MAX_DIGIT) | PAT_POINT;
            if (s2_lo_reg)
            begin
                item.patterns[0] = PAT_MINUS;
            end
        end
        item.scan = (s2_func_reg == FUNC_SCAN);
    end

    assign item_valid = s2_valid_reg;

endmodule

`default_nettype wire

// ===== sv/seven_segment_number_display_core.sv =====
// ----------------------------------------------------------------------------
// seven_segment_number_display_core
// decimal formatter and scan driver for a four-digit multiplexed display
// ----------------------------------------------------------------------------
// Takes one command transaction per clock cycle while disp.ready allows
// and gives one display transaction back for each, in order. A load
// (func 0) formats value_milli, a signed count of thousandths, into four
// digit patterns and answers with a dark display word (segments 0,
// digit_select 0). A scan tick (func 1) answers with the pattern of the
// current digit and its one-hot select, leftmost first, then moves to
// the next digit. Throughput is one transaction per cycle on both sides
// while disp.ready is high; a command's result reaches the result
// register through the input register, a range and magnitude stage, a
// reciprocal-multiply stage and the digit selection in front of the
// result register. Ticks pass through the same stages, so a tick always
// sees every load accepted before it. Values above 9999 show "9999." and
// values below -999 show "-999.". After reset the display is blank and
// the scan starts at the leftmost digit.
`default_nettype none

`include "seven_segment_number_display_core_macros.svh"

module seven_segment_number_display_core
    import ssnd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssnd_in_if.sink     cmd,
    ssnd_out_if.source  disp
);

    fmt_item_t              item;
    logic                   item_valid;
    logic                   take;
    logic                   move;
    logic                   load_move;
    logic                   scan_move;

    // digit pattern store and scan pointer
    pattern_set_t           pattern_reg, pattern_next;
    logic [SCAN_W-1:0]      scan_pos_reg, scan_pos_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [SEG_W-1:0]       segments_reg, segments_next;
    logic [DIGIT_COUNT-1:0] select_reg, select_next;

    // result register frees up when empty or when its transaction is taken
    assign take      = !out_valid_reg || disp.ready;
    assign move      = item_valid && take;
    assign load_move = move && !item.scan;
    assign scan_move = move && item.scan;

    ssnd_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    // a load rewrites all four patterns, a tick only moves the pointer
    assign pattern_next  = load_move ? item.patterns : pattern_reg;
    assign scan_pos_next = scan_move ? SCAN_W'(scan_pos_reg + 1'b1) : scan_pos_reg;

    // ticks read the store before any later load can change it
    assign out_valid_next = take ? item_valid : out_valid_reg;
    assign segments_next  = item.scan ? pattern_reg[scan_pos_reg] : PAT_BLANK;
    assign select_next    = item.scan ? (SEL_LEFT >> scan_pos_reg) : SEL_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            scan_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pattern_reg   <= pattern_next;
            scan_pos_reg  <= scan_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            segments_reg <= segments_next;
            select_reg   <= select_next;
        end
    end

    assign disp.valid        = out_valid_reg;
    assign disp.segments     = segments_reg;
    assign disp.digit_select = select_reg;

    // at most one digit driven, and a dark word carries no segments
    `SSND_ASSERT_NOW(a_select_onehot0, clk, rst_n, disp.valid, $onehot0(disp.digit_select), "digit select has more than one bit set")
    `SSND_ASSERT_NOW(a_dark_word_blank, clk, rst_n, disp.valid && (disp.digit_select == SEL_NONE), disp.segments == PAT_BLANK, "dark display word carries segments")
    // scan pointer steps by one per tick transaction
    `SSND_ASSERT_NEXT(a_scan_advance, clk, rst_n, scan_move, scan_pos_reg == SCAN_W'($past(scan_pos_reg) + 1'b1), "scan pointer did not advance")
    // only a load transaction may change the stored patterns
    `SSND_ASSERT_NEXT(a_patterns_hold, clk, rst_n, !load_move, $stable(pattern_reg), "patterns changed without a load")

endmodule

`default_nettype wire
